FILE: hw/rtl/socl_pkg.sv
// Package of shared constants, types and helpers for the sparse octree cell locator.
`default_nettype none

package socl_pkg;

	localparam int MAX_DEPTH     = 8;
	localparam int NODE_CAPACITY = 1024;
	localparam int LEAF_CAPACITY = 2048;
	localparam int FRACTION_BITS = 16;

	localparam int COORD_W    = 18;
	localparam int LEAF_IDX_W = 11;
	localparam int CFG_W      = 4;

	localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);
	localparam int NODE_IW = $clog2(NODE_CAPACITY);
	localparam int NU_W    = $clog2(NODE_CAPACITY + 1);
	localparam int LU_W    = $clog2(LEAF_CAPACITY + 1);
	localparam int NREF_W  = NU_W + 1;
	localparam int LREF_W  = LU_W + 1;
	localparam int REF_W   = (NREF_W > LREF_W) ? NREF_W : LREF_W;
	localparam int CHILD_DEPTH = 8 * NODE_CAPACITY;
	localparam int CHILD_AW    = NODE_IW + 3;

	localparam logic [CFG_W-1:0] DEPTH_RESET = CFG_W'(4);

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_OUTSIDE = 2'd1,
		ST_FULL    = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_EVAL = 4'b0010,
		S_ZERO = 4'b0100,
		S_READ = 4'b1000
	} state_t;

	// A coordinate lies in the unit cube when it is non-negative and below one.
	function automatic logic coord_outside(input logic signed [COORD_W-1:0] v);
		logic [31:0] mag;
		begin
			mag = 32'(v[COORD_W-2:0]);
			return v[COORD_W-1] || (mag >= 32'(1 << FRACTION_BITS));
		end
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/socl_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none

module socl_ram #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [DATA_W-1:0]        wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [DATA_W-1:0]        rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/sparse_octree_cell_locator.sv
// Top level of the sparse octree cell locator: sequencer, pools and result register.
`default_nettype none

// Each input transaction carries either a clear command (tuser high) or a point
// given as three signed coordinates with sixteen fraction bits. A point outside
// the unit cube is rejected at once; otherwise the block walks the octree from
// the root, taking one bit per axis at each level, and returns the index of the
// leaf cell, creating missing inner nodes and the leaf on demand. A clear or a
// rejected point is answered straight from the idle state. A lookup walks the
// tree one level at a time; the single port pair of the child-reference memory
// carries one read per level, and a new node puts a write of the parent entry
// in place of that read, then adds eight writes that zero its children and one
// read. The child memory is never swept: a new node zeroes its own entries before
// use, so no clearing pass follows reset or a clear. Writing depth_levels also
// empties the tree. The input is taken only while the sequencer is idle and the
// result register is free or being emptied.

module sparse_octree_cell_locator
	import socl_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_wr_en,
	input  wire logic [CFG_W-1:0]  cfg_wr_data,   // depth_levels
	input  wire logic              s_axis_tvalid,
	output logic                   s_axis_tready,
	input  wire logic [55:0]       s_axis_tdata,  // x_coord[17:0], y_coord[35:18], z_coord[53:36]
	input  wire logic              s_axis_tuser,  // command
	output logic                   m_axis_tvalid,
	input  wire logic              m_axis_tready,
	output logic [15:0]            m_axis_tdata,  // leaf_index[10:0], leaf_new[11]
	output logic [1:0]             m_axis_tuser   // status
);

	state_t state_q;

	logic [CFG_W-1:0]         depth_q;
	logic [REF_W-1:0]         root_q;
	logic [NU_W-1:0]          nodes_used_q;
	logic [LU_W-1:0]          leaves_used_q;

	// Walk context.
	logic [FRACTION_BITS-1:0] x_q, y_q, z_q;
	logic [DEPTH_W-1:0]       lvl_q;
	logic                     slot_is_root_q;
	logic [CHILD_AW-1:0]      slot_addr_q;
	logic [NODE_IW-1:0]       node_base_q;
	logic [2:0]               zc_q;

	// Result register.
	logic                     out_valid_q;
	status_t                  out_status_q;
	logic [LEAF_IDX_W-1:0]    out_index_q;
	logic                     out_new_q;

	// Child-reference memory.
	logic                     ram_we, ram_re;
	logic [CHILD_AW-1:0]      ram_waddr, ram_raddr;
	logic [REF_W-1:0]         ram_wdata, ram_rdata;

	logic                     out_free, accept;
	logic [DEPTH_W-1:0]       depth_eff;
	logic [REF_W-1:0]         cur_ref, new_node_ref, new_leaf_ref;
	logic [NODE_IW-1:0]       cur_node_idx;
	logic [2:0]               which;
	logic                     at_leaf, slot_empty, node_full, leaf_full;
	logic                     in_outside;

	logic signed [COORD_W-1:0] in_x, in_y, in_z;

	assign in_x = s_axis_tdata[17:0];
	assign in_y = s_axis_tdata[35:18];
	assign in_z = s_axis_tdata[53:36];

	assign out_free      = !out_valid_q || m_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE) && out_free;
	assign accept        = s_axis_tvalid && s_axis_tready;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_status_q;
	assign m_axis_tdata  = {4'b0, out_new_q, out_index_q};

	always_comb begin
		depth_eff = (int'(depth_q) > MAX_DEPTH) ? DEPTH_W'(MAX_DEPTH) : DEPTH_W'(depth_q);
		in_outside = coord_outside(in_x) || coord_outside(in_y) || coord_outside(in_z);

		// The slot under inspection is the root register or the last memory read.
		cur_ref      = slot_is_root_q ? root_q : ram_rdata;
		slot_empty   = (cur_ref == '0);
		at_leaf      = (lvl_q == depth_eff);
		which        = {z_q[FRACTION_BITS-1], y_q[FRACTION_BITS-1], x_q[FRACTION_BITS-1]};
		cur_node_idx = NODE_IW'((cur_ref >> 1) - REF_W'(1));
		new_node_ref = (REF_W'(nodes_used_q) + REF_W'(1)) << 1;
		new_leaf_ref = ((REF_W'(leaves_used_q) + REF_W'(1)) << 1) | REF_W'(1);
		node_full    = (nodes_used_q >= NU_W'(NODE_CAPACITY));
		leaf_full    = (leaves_used_q >= LU_W'(LEAF_CAPACITY));

		ram_we    = 1'b0;
		ram_waddr = slot_addr_q;
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = slot_addr_q;

		case (state_q)
			S_EVAL: begin
				if (!at_leaf) begin
					if (slot_empty) begin
						ram_we    = !node_full && !slot_is_root_q;
						ram_wdata = new_node_ref;
					end else begin
						ram_re    = 1'b1;
						ram_raddr = {cur_node_idx, which};
					end
				end else if (slot_empty) begin
					ram_we    = !leaf_full && !slot_is_root_q && out_free;
					ram_wdata = new_leaf_ref;
				end
			end
			S_ZERO: begin
				ram_we    = 1'b1;
				ram_waddr = {node_base_q, zc_q};
			end
			S_READ: begin
				ram_re = 1'b1;
			end
			default: begin
			end
		endcase
	end

	socl_ram #(
		.DATA_W(REF_W),
		.DEPTH (CHILD_DEPTH)
	) u_child_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// The coordinate registers of the walk context hold payload only and need no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q <= in_x[FRACTION_BITS-1:0];
			y_q <= in_y[FRACTION_BITS-1:0];
			z_q <= in_z[FRACTION_BITS-1:0];
		end else if (state_q == S_EVAL && !at_leaf && (!slot_empty || !node_full)) begin
			x_q <= x_q << 1;
			y_q <= y_q << 1;
			z_q <= z_q << 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			depth_q        <= DEPTH_RESET;
			root_q         <= '0;
			nodes_used_q   <= '0;
			leaves_used_q  <= '0;
			lvl_q          <= '0;
			slot_is_root_q <= 1'b1;
			slot_addr_q    <= '0;
			node_base_q    <= '0;
			zc_q           <= '0;
			out_valid_q    <= 1'b0;
			out_status_q   <= ST_OK;
			out_index_q    <= '0;
			out_new_q      <= 1'b0;
		end else begin
			if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end

			// A new depth means a fresh tree.
			if (cfg_wr_en) begin
				depth_q       <= cfg_wr_data;
				root_q        <= '0;
				nodes_used_q  <= '0;
				leaves_used_q <= '0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						lvl_q          <= '0;
						slot_is_root_q <= 1'b1;
						if (s_axis_tuser) begin
							root_q        <= '0;
							nodes_used_q  <= '0;
							leaves_used_q <= '0;
							out_valid_q   <= 1'b1;
							out_status_q  <= ST_OK;
							out_index_q   <= '0;
							out_new_q     <= 1'b0;
						end else if (in_outside) begin
							out_valid_q  <= 1'b1;
							out_status_q <= ST_OUTSIDE;
							out_index_q  <= '0;
							out_new_q    <= 1'b0;
						end else begin
							state_q <= S_EVAL;
						end
					end
				end
				S_EVAL: begin
					if (!at_leaf) begin
						if (slot_empty && node_full) begin
							if (out_free) begin
								out_valid_q  <= 1'b1;
								out_status_q <= ST_FULL;
								out_index_q  <= '0;
								out_new_q    <= 1'b0;
								state_q      <= S_IDLE;
							end
						end else if (slot_empty) begin
							// Hook in a new inner node, then zero its eight children.
							if (slot_is_root_q) begin
								root_q <= new_node_ref;
							end
							node_base_q    <= nodes_used_q[NODE_IW-1:0];
							slot_addr_q    <= {nodes_used_q[NODE_IW-1:0], which};
							nodes_used_q   <= nodes_used_q + NU_W'(1);
							slot_is_root_q <= 1'b0;
							lvl_q          <= lvl_q + DEPTH_W'(1);
							zc_q           <= '0;
							state_q        <= S_ZERO;
						end else begin
							slot_addr_q    <= {cur_node_idx, which};
							slot_is_root_q <= 1'b0;
							lvl_q          <= lvl_q + DEPTH_W'(1);
						end
					end else if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
						if (slot_empty && leaf_full) begin
							out_status_q <= ST_FULL;
							out_index_q  <= '0;
							out_new_q    <= 1'b0;
						end else if (slot_empty) begin
							if (slot_is_root_q) begin
								root_q <= new_leaf_ref;
							end
							leaves_used_q <= leaves_used_q + LU_W'(1);
							out_status_q  <= ST_OK;
							out_index_q   <= LEAF_IDX_W'(leaves_used_q);
							out_new_q     <= 1'b1;
						end else begin
							out_status_q <= ST_OK;
							out_index_q  <= LEAF_IDX_W'((cur_ref >> 1) - REF_W'(1));
							out_new_q    <= 1'b0;
						end
					end
				end
				S_ZERO: begin
					zc_q <= zc_q + 3'd1;
					if (zc_q == 3'd7) begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_EVAL;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// The pools never grow past their capacity.
	assert property (@(posedge clk) disable iff (!arst_n)
		(nodes_used_q <= NU_W'(NODE_CAPACITY)) && (leaves_used_q <= LU_W'(LEAF_CAPACITY)))
	else $error("pool count beyond capacity");

	// Zeroing a new node writes zeros to the memory on every cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ZERO) |-> (ram_we && ram_wdata == '0 && !ram_re))
	else $error("node zeroing pass broken");

	// A failed or rejected result never reports a leaf.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_status_q != ST_OK) |-> (out_index_q == '0 && !out_new_q))
	else $error("error result carries a leaf");

	// A newly created leaf is always the last one taken from the pool.
	assert property (@(posedge clk) disable iff (!arst_n)
		($rose(out_valid_q) && out_new_q)
		|-> (LU_W'(out_index_q) + LU_W'(1) == leaves_used_q))
	else $error("new leaf index does not match pool count");

endmodule

`default_nettype wire

FILE: tb/sv/socl_checker.sv
// Checker for the sparse octree cell locator: mirrors the tree and scores every result.
`timescale 1ns / 1ps

module socl_checker
	import socl_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_wr_en,
	input  wire logic [CFG_W-1:0] cfg_wr_data,
	input  wire logic             s_axis_tvalid,
	input  wire logic             s_axis_tready,
	input  wire logic [55:0]      s_axis_tdata,
	input  wire logic             s_axis_tuser,
	input  wire logic             m_axis_tvalid,
	input  wire logic             m_axis_tready,
	input  wire logic [15:0]      m_axis_tdata,
	input  wire logic [1:0]       m_axis_tuser,
	output int                    failures,
	output int                    pending,
	output int                    found_count,
	output int                    outside_count,
	output int                    full_count,
	output int                    created_count,
	output int                    clear_count
);

	typedef struct packed {
		status_t                 status;
		logic [LEAF_IDX_W-1:0]   leaf_index;
		logic                    leaf_new;
	} cell_result_t;

	logic [CFG_W-1:0]  depth_setting;
	logic [REF_W-1:0]  root_ref;
	logic [REF_W-1:0]  child_ref [CHILD_DEPTH];
	logic [NU_W-1:0]   nodes_alloc;
	logic [LU_W-1:0]   leaves_alloc;
	cell_result_t      awaited_q [$];
	int                result_no;

	function automatic void empty_tree();
		root_ref     = '0;
		nodes_alloc  = '0;
		leaves_alloc = '0;
	endfunction

	// A negative slot number stands for the root reference.
	function automatic void store_ref(input int slot, input logic [REF_W-1:0] value);
		if (slot < 0) begin
			root_ref = value;
		end else begin
			child_ref[slot] = value;
		end
	endfunction

	task automatic locate_cell(input logic [COORD_W-1:0] xc, yc, zc, output cell_result_t r);
		logic signed [COORD_W-1:0] coord [3];
		logic [MAX_DEPTH-1:0]      grid [3];
		logic [2:0]                which;
		logic [REF_W-1:0]          cur;
		int                        depth, slot, lvl, a;
		r.status     = ST_OK;
		r.leaf_index = '0;
		r.leaf_new   = 1'b0;
		coord[0] = xc;
		coord[1] = yc;
		coord[2] = zc;
		depth = (depth_setting > MAX_DEPTH) ? MAX_DEPTH : int'(depth_setting);
		for (a = 0; a < 3; a++) begin
			if (coord[a] < 0 || coord[a] >= (1 << FRACTION_BITS)) begin
				r.status = ST_OUTSIDE;
				return;
			end
			grid[a] = MAX_DEPTH'(coord[a] >> (FRACTION_BITS - depth));
		end
		slot = -1;
		cur  = root_ref;
		for (lvl = depth; lvl > 0; lvl--) begin
			which = {grid[2][lvl-1], grid[1][lvl-1], grid[0][lvl-1]};
			if (cur == '0) begin
				if (nodes_alloc >= NODE_CAPACITY) begin
					r.status = ST_FULL;
					return;
				end
				for (a = 0; a < 8; a++)
					child_ref[int'(nodes_alloc) * 8 + a] = '0;
				cur = REF_W'((int'(nodes_alloc) + 1) << 1);
				store_ref(slot, cur);
				nodes_alloc++;
			end
			slot = ((int'(cur) >> 1) - 1) * 8 + int'(which);
			cur  = child_ref[slot];
		end
		if (cur == '0) begin
			if (leaves_alloc >= LEAF_CAPACITY) begin
				r.status = ST_FULL;
				return;
			end
			cur = REF_W'(((int'(leaves_alloc) + 1) << 1) | 1);
			store_ref(slot, cur);
			leaves_alloc++;
			r.leaf_new = 1'b1;
		end
		r.leaf_index = LEAF_IDX_W'((int'(cur) >> 1) - 1);
	endtask

	always @(posedge clk or negedge arst_n) begin : scoreboard
		cell_result_t fresh, awaited;
		if (!arst_n) begin
			depth_setting = DEPTH_RESET;
			empty_tree();
			awaited_q.delete();
			pending       <= 0;
			failures      = 0;
			found_count   = 0;
			outside_count = 0;
			full_count    = 0;
			created_count = 0;
			clear_count   = 0;
			result_no     = 0;
		end else begin
			// Results are retired before new work is queued, so a result can
			// never be matched against an item accepted on the same edge.
			if (m_axis_tvalid && m_axis_tready) begin
				if (awaited_q.size() == 0) begin
					if (failures < 10)
						$display("Result %0d arrived with nothing outstanding (tuser %0d tdata %h)",
							result_no, m_axis_tuser, m_axis_tdata);
					failures++;
				end else begin
					awaited = awaited_q.pop_front();
					if (m_axis_tuser !== awaited.status || m_axis_tdata[10:0] !== awaited.leaf_index
							|| m_axis_tdata[11] !== awaited.leaf_new || m_axis_tdata[15:12] !== 4'b0) begin
						if (failures < 10)
							$display({"Result %0d mismatch: expected status %0d leaf %0d new %0d, ",
								"got status %0d leaf %0d new %0d (tdata %h)"},
								result_no, awaited.status, awaited.leaf_index, awaited.leaf_new,
								m_axis_tuser, m_axis_tdata[10:0], m_axis_tdata[11], m_axis_tdata);
						failures++;
					end
					case (awaited.status)
						ST_OK:      found_count++;
						ST_OUTSIDE: outside_count++;
						default:    full_count++;
					endcase
					if (awaited.leaf_new)
						created_count++;
				end
				result_no++;
			end
			if (cfg_wr_en) begin
				depth_setting = cfg_wr_data;
				empty_tree();
			end
			if (s_axis_tvalid && s_axis_tready) begin
				if (s_axis_tuser) begin
					empty_tree();
					fresh.status     = ST_OK;
					fresh.leaf_index = '0;
					fresh.leaf_new   = 1'b0;
					clear_count++;
				end else begin
					locate_cell(s_axis_tdata[17:0], s_axis_tdata[35:18], s_axis_tdata[53:36], fresh);
				end
				awaited_q.push_back(fresh);
			end
			pending <= awaited_q.size();
		end
	end

endmodule

FILE: tb/sv/sparse_octree_cell_locator_test.sv
// Testbench top for the sparse octree cell locator: stimulus, flow control and verdict.
`timescale 1ns / 1ps

// The top drives points and clear commands into the block, stalls both sides of
// the stream in random bursts and sets the depth register to every code from
// zero to nine and to fifteen, including codes above the maximum. The checker beside
// the block predicts every result and counts mismatches; this module only makes
// stimulus and reports the verdict.
module sparse_octree_cell_locator_test;
	import socl_pkg::*;

	// The slowest lookup creates eight inner nodes, and both sides may stall in
	// random bursts on each transaction. Around two thousand transactions at that
	// cost stay well under this limit.
	localparam int CYCLE_LIMIT  = 2_000_000;
	// Enough cycles for a full-depth walk to finish after the last result.
	localparam int DRAIN_CYCLES = 120;
	// Distinct cells visited by the dense leaf fill.
	localparam int FILL_CELLS   = 1120;

	localparam logic [COORD_W-1:0] C_ZERO     = 18'h00000;
	localparam logic [COORD_W-1:0] C_TOP      = 18'h0FFFF;
	localparam logic [COORD_W-1:0] C_ONE      = 18'h10000;
	localparam logic [COORD_W-1:0] C_NEG_ONE  = 18'h3FFFF;
	localparam logic [COORD_W-1:0] C_MOST_NEG = 18'h20000;
	localparam logic [COORD_W-1:0] C_MOST_POS = 18'h1FFFF;
	localparam logic [COORD_W-1:0] C_EIGHTH   = 18'h01000;

	localparam logic CMD_LOCATE = 1'b0;
	localparam logic CMD_CLEAR  = 1'b1;

	logic              clk           = 1'b0;
	logic              arst_n        = 1'b0;
	logic              cfg_wr_en     = 1'b0;
	logic [CFG_W-1:0]  cfg_wr_data   = '0;
	logic              s_axis_tvalid = 1'b0;
	logic [55:0]       s_axis_tdata  = '0;
	logic              s_axis_tuser  = 1'b0;
	logic              m_axis_tready = 1'b0;
	wire logic         s_axis_tready;
	wire logic         m_axis_tvalid;
	wire logic [15:0]  m_axis_tdata;
	wire logic [1:0]   m_axis_tuser;

	int failures, pending, found_count, outside_count, full_count, created_count, clear_count;

	// When calm is set, neither side of the stream idles.
	logic calm       = 1'b0;
	int   stall_left = 0;
	int   cycles     = 0;

	// Recently located points, replayed so that existing leaves are found again.
	logic [3*COORD_W-1:0] visited_points [$];

	sparse_octree_cell_locator uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	socl_checker chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.failures      (failures),
		.pending       (pending),
		.found_count   (found_count),
		.outside_count (outside_count),
		.full_count    (full_count),
		.created_count (created_count),
		.clear_count   (clear_count)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// A hung block would otherwise keep the run going for ever.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Run stopped after %0d cycles with %0d results outstanding.", cycles, pending);
			$display("sparse_octree_cell_locator_test: errors");
			$finish;
		end
	end

	// The result side holds tready low in random bursts.
	always @(posedge clk) begin
		if (calm) begin
			m_axis_tready <= 1'b1;
		end else if (stall_left != 0) begin
			stall_left    <= stall_left - 1;
			m_axis_tready <= 1'b0;
		end else if ($urandom_range(0, 5) == 0) begin
			stall_left    <= $urandom_range(0, 7);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Offers one transaction and returns at the edge that accepts it. tvalid is
	// left high so that back-to-back transactions need no gap between them.
	task automatic send_item(input logic cmd, input logic [COORD_W-1:0] xc, yc, zc);
		if (!calm && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= cmd;
		s_axis_tdata  <= {2'b00, zc, yc, xc};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// Stops offering and waits until every expected result has come back.
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// The depth register is only written while the block is idle. Every write
	// also empties the tree, which the checker follows.
	task automatic set_depth(input logic [CFG_W-1:0] depth);
		settle();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= depth;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	function automatic logic [COORD_W-1:0] unit_coord();
		return COORD_W'($urandom_range(0, (1 << FRACTION_BITS) - 1));
	endfunction

	// A coordinate just outside, far outside or at the edges of the field range.
	function automatic logic [COORD_W-1:0] stray_coord();
		case ($urandom_range(0, 3))
			0:       return {1'b1, 17'($urandom)};
			1:       return COORD_W'($urandom_range(1 << FRACTION_BITS, (1 << (COORD_W - 1)) - 1));
			2:       return $urandom_range(0, 1) ? C_ONE : C_NEG_ONE;
			default: return $urandom_range(0, 1) ? C_MOST_POS : C_MOST_NEG;
		endcase
	endfunction

	// Mostly fresh points inside the cube and replays of earlier ones, with a share
	// of rejected points and, at the given rate, clear commands.
	task automatic random_item(input int clear_pct);
		logic [COORD_W-1:0]   c [3];
		logic [3*COORD_W-1:0] p;
		int                   pick;
		pick = $urandom_range(0, 99);
		if (pick < clear_pct) begin
			send_item(CMD_CLEAR, 18'($urandom), 18'($urandom), 18'($urandom));
		end else if (pick < clear_pct + 10) begin
			c[0] = 18'($urandom);
			c[1] = 18'($urandom);
			c[2] = 18'($urandom);
			c[$urandom_range(0, 2)] = stray_coord();
			send_item(CMD_LOCATE, c[0], c[1], c[2]);
		end else if (pick < clear_pct + 30 && visited_points.size() != 0) begin
			p = visited_points[$urandom_range(0, visited_points.size() - 1)];
			send_item(CMD_LOCATE, p[17:0], p[35:18], p[53:36]);
		end else begin
			c[0] = unit_coord();
			c[1] = unit_coord();
			c[2] = unit_coord();
			send_item(CMD_LOCATE, c[0], c[1], c[2]);
			visited_points.push_back({c[2], c[1], c[0]});
			if (visited_points.size() > 64)
				void'(visited_points.pop_front());
		end
	endtask

	task automatic run_phase(input logic [CFG_W-1:0] depth, input int count, input int clear_pct);
		set_depth(depth);
		visited_points.delete();
		repeat (count) random_item(clear_pct);
	endtask

	// At depth four the inner nodes fit easily, so visiting distinct cells fills a
	// large part of the leaf pool with consecutive new leaves. The stride is odd,
	// hence every step lands on a new cell. Afterwards a few of those cells are
	// visited again and their existing leaves must be found.
	task automatic fill_leaf_pool();
		logic [11:0] grid_no;
		int          n;
		set_depth(4'd4);
		for (n = 0; n < FILL_CELLS; n++) begin
			grid_no = 12'(n * 1237);
			send_item(CMD_LOCATE,
				COORD_W'({grid_no[3:0], 12'($urandom)}),
				COORD_W'({grid_no[7:4], 12'($urandom)}),
				COORD_W'({grid_no[11:8], 12'($urandom)}));
		end
		repeat (16) begin
			grid_no = 12'($urandom_range(0, FILL_CELLS - 1) * 1237);
			send_item(CMD_LOCATE,
				COORD_W'({grid_no[3:0], 12'($urandom)}),
				COORD_W'({grid_no[7:4], 12'($urandom)}),
				COORD_W'({grid_no[11:8], 12'($urandom)}));
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset depth of four: two opposite corners of the cube, each
		// axis stepping out of range on its own, the extremes of the field, a
		// revisit of an existing cell and a clear followed by a rebuild.
		send_item(CMD_LOCATE, C_ZERO, C_ZERO, C_ZERO);
		send_item(CMD_LOCATE, C_ZERO, C_ZERO, C_ZERO);
		send_item(CMD_LOCATE, C_TOP, C_TOP, C_TOP);
		send_item(CMD_LOCATE, C_ONE, C_ZERO, C_ZERO);
		send_item(CMD_LOCATE, C_ZERO, C_ONE, C_ZERO);
		send_item(CMD_LOCATE, C_ZERO, C_ZERO, C_ONE);
		send_item(CMD_LOCATE, C_NEG_ONE, C_ZERO, C_ZERO);
		send_item(CMD_LOCATE, C_MOST_NEG, C_ZERO, C_ZERO);
		send_item(CMD_LOCATE, C_MOST_POS, C_MOST_POS, C_MOST_POS);
		send_item(CMD_LOCATE, C_EIGHTH, C_ZERO, C_ZERO);
		send_item(CMD_LOCATE, C_ZERO, C_EIGHTH, C_ZERO);
		send_item(CMD_LOCATE, C_ZERO, C_ZERO, C_EIGHTH);
		send_item(CMD_LOCATE, 18'h00FFF, C_ZERO, C_ZERO);
		send_item(CMD_CLEAR, C_NEG_ONE, C_MOST_NEG, C_MOST_POS);
		send_item(CMD_LOCATE, C_TOP, C_TOP, C_TOP);
		send_item(CMD_LOCATE, 18'h08000, 18'h04000, 18'h02000);

		// At depth zero the root is the leaf, so every point inside shares it.
		set_depth(4'd0);
		send_item(CMD_LOCATE, C_ZERO, C_ZERO, C_ZERO);
		send_item(CMD_LOCATE, C_TOP, C_TOP, C_TOP);
		send_item(CMD_LOCATE, C_ONE, C_ZERO, C_ZERO);
		send_item(CMD_CLEAR, C_ZERO, C_ZERO, C_ZERO);
		send_item(CMD_LOCATE, 18'h01234, 18'h08000, C_TOP);

		// Random part. At the full depth, with no clears, the node pool runs out
		// within a few hundred points; codes above the maximum act as full depth.
		run_phase(4'd0, 20, 5);
		run_phase(4'd1, 30, 3);
		run_phase(4'd8, 220, 0);
		run_phase(4'd15, 80, 1);
		run_phase(4'd2, 30, 3);
		run_phase(4'd3, 50, 2);
		fill_leaf_pool();
		run_phase(4'd9, 60, 2);
		run_phase(4'd6, 60, 1);
		run_phase(4'd7, 60, 0);

		// The last part runs with no idling on either side.
		calm <= 1'b1;
		run_phase(4'd5, 80, 2);

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d results: %0d found, %0d outside the cube, %0d pool full, %0d clears.",
			found_count + outside_count + full_count, found_count, outside_count, full_count,
			clear_count);
		$display("Leaves created: %0d; depth register taken through zero, the maximum and above.",
			created_count);
		if (failures == 0 && pending == 0) begin
			$display("sparse_octree_cell_locator_test: clean");
		end else begin
			$display("sparse_octree_cell_locator_test: errors");
		end
		$finish;
	end

endmodule
